/* rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; every other file in rtl/ imports this package.
package uer_pkg;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ECHO = 2'd1;
  localparam logic [1:0] ST_CAPPED  = 2'd2;

  // Unit select codes (the unused code falls back to millimetres)
  localparam logic [1:0] UNIT_MM = 2'd0;
  localparam logic [1:0] UNIT_CM = 2'd1;
  localparam logic [1:0] UNIT_IN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [1:0] CFG_RISE_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_MAX_WIDTH     = 2'd2;
  localparam logic [1:0] CFG_UNIT_MODE     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd10;
  localparam logic [15:0] RST_RISE_TIMEOUT  = 16'd2500;
  localparam logic [15:0] RST_MAX_WIDTH     = 16'd25000;
  localparam logic [1:0]  RST_UNIT_MODE     = UNIT_MM;

  // Field widths
  localparam int WIDTH_W = 16;  // echo width never exceeds the 16-bit cap register
  localparam int DIST_W  = 14;

  // Reciprocal multipliers: floor(x/d) = (x*M) >> S, exact over the input range.
  // Millimetres: x = width*10 (< 2^20), d = 58
  // Centimetres: x = width (< 2^16), d = 58
  // Inches:      x = width (< 2^16), d = 148
  localparam int DIV_X_W = 20;
  localparam int DIV_M_W = 21;
  localparam int DIV_P_W = DIV_X_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] MM_MUL = 21'd1157050;
  localparam logic [DIV_M_W-1:0] CM_MUL = 21'd72316;
  localparam logic [DIV_M_W-1:0] IN_MUL = 21'd113360;
  localparam int MM_SHIFT = 26;
  localparam int CM_SHIFT = 22;
  localparam int IN_SHIFT = 24;

  // Configuration seen by the phase machine
  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [15:0] rise_timeout;
    logic [15:0] max_width;
  } cfg_t;

  // Per-tick result before unit conversion
  typedef struct packed {
    logic               trig;
    logic               done;
    logic [1:0]         status;
    logic [WIDTH_W-1:0] width;
  } raw_res_t;

endpackage

/* rtl/uer_fsm.sv */
// Phase machine and tick counter of the echo ranger: one tick per accepted item.
// Depends on uer_pkg (phase_t, cfg_t, raw_res_t, status codes).
module uer_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              start_req,
  input  logic              echo_level,
  input  uer_pkg::cfg_t     cfg,
  output uer_pkg::raw_res_t res
);
  import uer_pkg::*;

  localparam int LW = (COUNT_WIDTH > WIDTH_W) ? COUNT_WIDTH : WIDTH_W;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);
  localparam logic [LW-1:0] CMAX_EXT = LW'(CMAX);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] lim_trig, lim_rise, lim_width;

  // Zero acts as one; clamp to what the counter can reach
  function automatic logic [COUNT_WIDTH-1:0] eff_limit(input logic [15:0] reg_val);
    logic [15:0]   lim16;
    logic [LW-1:0] ext;
    lim16 = (reg_val == 16'd0) ? 16'd1 : reg_val;
    ext   = LW'(lim16);
    if (ext > CMAX_EXT) begin
      ext = CMAX_EXT;
    end
    return ext[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH_W-1:0] to_width(input logic [COUNT_WIDTH-1:0] c);
    logic [LW-1:0] ext;
    ext = LW'(c);
    return ext[WIDTH_W-1:0];
  endfunction

  assign lim_trig  = eff_limit({8'd0, cfg.trigger_ticks});
  assign lim_rise  = eff_limit(cfg.rise_timeout);
  assign lim_width = eff_limit(cfg.max_width);

  // Saturating increment
  assign cnt_inc = (cnt_r == CMAX) ? cnt_r : cnt_r + ONE;

  // Hold state between ticks, advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next phase, next count and this tick's raw result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    res.trig   = 1'b0;
    res.done   = 1'b0;
    res.status = ST_OK;
    res.width  = '0;
    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          res.trig = 1'b1;
          if (lim_trig == ONE) begin
            phase_nxt = PH_WAIT;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_TRIG;
            cnt_nxt   = ONE;
          end
        end
      end
      PH_TRIG: begin
        res.trig = 1'b1;
        if (cnt_inc >= lim_trig) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          if (lim_width == ONE) begin
            res.done   = 1'b1;
            res.status = ST_CAPPED;
            res.width  = to_width(ONE);
            phase_nxt  = PH_IDLE;
            cnt_nxt    = '0;
          end else begin
            phase_nxt = PH_MEAS;
            cnt_nxt   = ONE;
          end
        end else if (cnt_inc >= lim_rise) begin
          // no rise in time: report no echo with zero width
          res.done   = 1'b1;
          res.status = ST_NO_ECHO;
          phase_nxt  = PH_IDLE;
          cnt_nxt    = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          if (cnt_inc >= lim_width) begin
            res.done   = 1'b1;
            res.status = ST_CAPPED;
            res.width  = to_width(cnt_inc);
            phase_nxt  = PH_IDLE;
            cnt_nxt    = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end else begin
          // echo fell: width is the count so far
          res.done   = 1'b1;
          res.status = ST_OK;
          res.width  = to_width(cnt_r);
          phase_nxt  = PH_IDLE;
          cnt_nxt    = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

endmodule

/* rtl/uer_dist.sv */
// Echo width to distance conversion by reciprocal multiplication.
// Depends on uer_pkg (unit codes, multiplier constants, field widths).
module uer_dist (
  input  logic [uer_pkg::WIDTH_W-1:0] width,
  input  logic [1:0]                  unit_mode,
  output logic [uer_pkg::DIST_W-1:0]  distance
);
  import uer_pkg::*;

  logic [DIV_X_W-1:0] x;
  logic [DIV_M_W-1:0] m;
  logic [DIV_P_W-1:0] prod;

  // Pick dividend and reciprocal for the selected unit
  always_comb begin
    case (unit_mode)
      UNIT_CM: begin
        x = DIV_X_W'(width);
        m = CM_MUL;
      end
      UNIT_IN: begin
        x = DIV_X_W'(width);
        m = IN_MUL;
      end
      default: begin
        // millimetres: width*10 as two shifts
        x = (DIV_X_W'(width) << 3) + (DIV_X_W'(width) << 1);
        m = MM_MUL;
      end
    endcase
  end

  assign prod = DIV_P_W'(x) * DIV_P_W'(m);

  // Drop the fraction bits
  always_comb begin
    case (unit_mode)
      UNIT_CM: distance = prod[CM_SHIFT +: DIST_W];
      UNIT_IN: distance = prod[IN_SHIFT +: DIST_W];
      default: distance = prod[MM_SHIFT +: DIST_W];
    endcase
  end

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Top level of the ultrasonic echo ranger: config registers, two-stage pipeline.
// Depends on uer_pkg, uer_fsm and uer_dist.
//
// One item is one microsecond tick: start request and sampled echo level in,
// trigger level, done flag, status and distance out, one result item for every
// input item. The block takes an item every clock cycle while in_stall is low;
// in_stall is raised when stage 1 holds an item that a stalled output blocks.
// The result of an item is registered in stage 1 and then in the output
// register before the receiver can take it. The first stage is the phase
// machine, which updates phase and tick counter once per item; the
// second stage converts the echo width with one reciprocal multiply. A start
// raises the trigger for trigger_ticks ticks, then the block waits up to
// rise_timeout low ticks for the echo (status 1, distance 0 on timeout) and
// counts the high time up to max_width (status 2 when capped). Distance is
// floor(width*10/58) mm, floor(width/58) cm or floor(width/148) in by unit_mode.
// Write configuration only while no measurement is running.
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic                          in_echo_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trigger_out,
  output logic                          out_done_res,
  output logic [1:0]                    out_status,
  output logic [uer_pkg::DIST_W-1:0]    out_distance,
  // configuration port
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import uer_pkg::*;

  logic [7:0]  trigger_ticks_r;
  logic [15:0] rise_timeout_r;
  logic [15:0] max_width_r;
  logic [1:0]  unit_mode_r;
  cfg_t        cfg;

  logic        in_acc;
  logic        s1_ready;
  logic        out_adv;
  raw_res_t    fsm_res;
  raw_res_t    s1_res_r;
  logic        s1_valid_r;
  logic [DIST_W-1:0] conv_dist;

  logic        out_valid_r;
  logic        out_trig_r;
  logic        out_done_r;
  logic [1:0]  out_status_r;
  logic [DIST_W-1:0] out_dist_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= RST_TRIGGER_TICKS;
      rise_timeout_r  <= RST_RISE_TIMEOUT;
      max_width_r     <= RST_MAX_WIDTH;
      unit_mode_r     <= RST_UNIT_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[7:0];
        CFG_RISE_TIMEOUT:  rise_timeout_r  <= cfg_wdata;
        CFG_MAX_WIDTH:     max_width_r     <= cfg_wdata;
        CFG_UNIT_MODE:     unit_mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg.trigger_ticks = trigger_ticks_r;
  assign cfg.rise_timeout  = rise_timeout_r;
  assign cfg.max_width     = max_width_r;

  // Handshake: each stage moves when the one after it has room
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || out_adv;
  assign in_stall = !s1_ready;
  assign in_acc   = in_valid && s1_ready;

  uer_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .start_req  (in_start_req),
    .echo_level (in_echo_level),
    .cfg        (cfg),
    .res        (fsm_res)
  );

  // Stage 1: raw tick result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= fsm_res;
    end
  end

  uer_dist u_dist (
    .width     (s1_res_r.width),
    .unit_mode (unit_mode_r),
    .distance  (conv_dist)
  );

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_trig_r   <= s1_res_r.trig;
      out_done_r   <= s1_res_r.done;
      out_status_r <= s1_res_r.status;
      out_dist_r   <= conv_dist;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_trigger_out = out_trig_r;
  assign out_done_res    = out_done_r;
  assign out_status      = out_status_r;
  assign out_distance    = out_dist_r;

  // An accepted item always lands in stage 1
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item did not reach stage 1");

  // A blocked stage 1 keeps its item
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(s1_res_r)))
    else $error("stage 1 item lost under stall");

  // Ticks that finish nothing carry zero status and distance
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> (out_status_r == ST_OK && out_dist_r == '0))
    else $error("non-done tick with nonzero status or distance");

  // No echo always reports zero distance
  a_no_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r && out_status_r == ST_NO_ECHO) |-> (out_dist_r == '0))
    else $error("no-echo result with nonzero distance");

endmodule

/* tb/tb_ultrasonic_echo_ranger.sv */
// Testbench for ultrasonic_echo_ranger: per-tick prediction of trigger, done, status, distance.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL; self-contained otherwise.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int DRAIN_CYCLES  = 10;
  localparam int MISMATCH_SHOW = 10;

  typedef struct packed {
    logic              trig;
    logic              done;
    logic [1:0]        status;
    logic [DIST_W-1:0] dist_val;
  } tick_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_start_req;
  logic                  in_echo_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_trigger_out;
  logic                  out_done_res;
  logic [1:0]            out_status;
  logic [DIST_W-1:0]     out_distance;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Ranger state and register copies mirrored by the predictor
  phase_t      ranger_phase = PH_IDLE;
  logic [15:0] ranger_count = '0;
  logic [7:0]  trig_len     = RST_TRIGGER_TICKS;
  logic [15:0] rise_limit   = RST_RISE_TIMEOUT;
  logic [15:0] width_cap    = RST_MAX_WIDTH;
  logic [1:0]  unit_sel     = RST_UNIT_MODE;

  tick_result_t tick_result_q[$];
  int           mismatch_count = 0;
  int           active_items   = 0;
  int           burst_left     = 0;
  bit           sender_steady  = 1'b0;
  int           cycle_count    = 0;

  ultrasonic_echo_ranger u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_req    (in_start_req),
    .in_echo_level   (in_echo_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_trigger_out (out_trigger_out),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_distance    (out_distance),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A zero limit register behaves as one
  function automatic int count_limit(input logic [15:0] reg_val);
    return (reg_val == 16'd0) ? 1 : int'(reg_val);
  endfunction

  // Convert an echo width to the selected unit, truncating
  function automatic logic [DIST_W-1:0] width_to_dist(input logic [15:0] w);
    int d;
    case (unit_sel)
      UNIT_CM: d = int'(w) / 58;
      UNIT_IN: d = int'(w) / 148;
      default: d = (int'(w) * 10) / 58;
    endcase
    return d[DIST_W-1:0];
  endfunction

  // Advance the ranger by one tick and return what it drives on that tick
  function automatic tick_result_t ranger_tick(input logic start, input logic echo);
    tick_result_t r;
    r = '0;
    case (ranger_phase)
      PH_IDLE: begin
        if (start) begin
          r.trig = 1'b1;
          ranger_count = 16'd1;
          if (int'(ranger_count) >= count_limit({8'd0, trig_len})) begin
            ranger_phase = PH_WAIT;
            ranger_count = '0;
          end else begin
            ranger_phase = PH_TRIG;
          end
        end
      end
      PH_TRIG: begin
        r.trig = 1'b1;
        if (ranger_count != 16'hFFFF) ranger_count++;
        if (int'(ranger_count) >= count_limit({8'd0, trig_len})) begin
          ranger_phase = PH_WAIT;
          ranger_count = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          ranger_count = 16'd1;
          if (int'(ranger_count) >= count_limit(width_cap)) begin
            r.done = 1'b1;
            r.status = ST_CAPPED;
            r.dist_val = width_to_dist(ranger_count);
            ranger_phase = PH_IDLE;
            ranger_count = '0;
          end else begin
            ranger_phase = PH_MEAS;
          end
        end else begin
          if (ranger_count != 16'hFFFF) ranger_count++;
          if (int'(ranger_count) >= count_limit(rise_limit)) begin
            r.done = 1'b1;
            r.status = ST_NO_ECHO;
            ranger_phase = PH_IDLE;
            ranger_count = '0;
          end
        end
      end
      default: begin
        if (echo) begin
          if (ranger_count != 16'hFFFF) ranger_count++;
          if (int'(ranger_count) >= count_limit(width_cap)) begin
            r.done = 1'b1;
            r.status = ST_CAPPED;
            r.dist_val = width_to_dist(ranger_count);
            ranger_phase = PH_IDLE;
            ranger_count = '0;
          end
        end else begin
          r.done = 1'b1;
          r.status = ST_OK;
          r.dist_val = width_to_dist(ranger_count);
          ranger_phase = PH_IDLE;
          ranger_count = '0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic coin();
    return $urandom_range(0, 1) != 0;
  endfunction

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOW)
        $display("%0t: %s expected %0d got %0d", $realtime, field, want, got);
    end
  endfunction

  // Compare each delivered item with the oldest pending prediction
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (tick_result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOW)
          $display("%0t: result with none pending: trig %0d done %0d status %0d dist %0d",
                   $realtime, out_trigger_out, out_done_res, out_status, out_distance);
      end else begin
        want = tick_result_q.pop_front();
        check_field("trigger_out", 16'(want.trig), 16'(out_trigger_out));
        check_field("done_res", 16'(want.done), 16'(out_done_res));
        check_field("status", 16'(want.status), 16'(out_status));
        check_field("distance", 16'(want.dist_val), 16'(out_distance));
      end
    end
  end

  // Receiver: stall on a pattern picked at random among four modes
  initial begin
    int rx_mode;
    int rx_left;
    rx_mode = 0;
    rx_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (rx_left % 3 == 0);
        default: out_stall <= (rx_left % 8 < 5);
      endcase
    end
  end

  // Cycle watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ultrasonic_echo_ranger: mismatch");
    $finish;
  end

  // Send one tick item, holding it until accepted, then predict its result
  task automatic send_tick(input logic start, input logic echo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!sender_steady && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 4);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (ranger_phase != PH_IDLE || start) active_items++;
    tick_result_q.push_back(ranger_tick(start, echo));
  endtask

  // Drive the running measurement to its end by the shortest path
  task automatic finish_measurement();
    while (ranger_phase != PH_IDLE)
      send_tick(1'b0, ranger_phase == PH_WAIT);
  endtask

  // Finish any measurement, drop valid and hold until every result is back
  task automatic quiesce();
    finish_measurement();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tick_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRIGGER_TICKS: trig_len   = val[7:0];
      CFG_RISE_TIMEOUT:  rise_limit = val;
      CFG_MAX_WIDTH:     width_cap  = val;
      default:           unit_sel   = val[1:0];
    endcase
  endtask

  task automatic configure(input logic [7:0] trig, input logic [15:0] timeout,
                           input logic [15:0] cap, input logic [1:0] units);
    quiesce();
    write_reg(CFG_TRIGGER_TICKS, {8'd0, trig});
    write_reg(CFG_RISE_TIMEOUT, timeout);
    write_reg(CFG_MAX_WIDTH, cap);
    write_reg(CFG_UNIT_MODE, {14'd0, units});
  endtask

  // One start request, rise_delay low ticks, then up to high_ticks echo-high ticks
  // and a fall; start and echo are random while the trigger is high
  task automatic run_measurement(input int rise_delay, input int high_ticks);
    int n;
    send_tick(1'b1, coin());
    while (ranger_phase == PH_TRIG) send_tick(coin(), coin());
    n = 0;
    while (ranger_phase == PH_WAIT && n < rise_delay) begin
      send_tick(coin(), 1'b0);
      n++;
    end
    n = 0;
    while (ranger_phase != PH_IDLE && n < high_ticks) begin
      send_tick(coin(), 1'b1);
      n++;
    end
    if (ranger_phase == PH_MEAS) send_tick(coin(), 1'b0);
    finish_measurement();
  endtask

  // Register values after reset: default trigger length, millimetres, echo fall
  task automatic test_reset_values();
    send_tick(1'b0, 1'b1);
    run_measurement(8, 20);
  endtask

  // Shortest trigger, one-tick timeout and cap, zero registers, ignored starts
  task automatic test_directed_corners();
    configure(8'd1, 16'd2, 16'd3, UNIT_MM);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    run_measurement(5, 0);
    run_measurement(0, 5);
    run_measurement(1, 1);
    configure(8'd0, 16'd0, 16'd0, UNIT_IN);
    run_measurement(0, 2);
    run_measurement(3, 0);
    configure(8'd2, 16'd4, 16'd1, UNIT_CM);
    run_measurement(1, 3);
  endtask

  // Every unit code, the unused one included, over widths with nonzero distances
  task automatic test_unit_modes();
    int u;
    int high;
    for (u = 0; u < 4; u++) begin
      configure(8'($urandom_range(1, 4)), 16'd50, 16'd2000, 2'(u));
      case (2'(u))
        UNIT_CM: high = $urandom_range(58, 64);
        UNIT_IN: high = $urandom_range(148, 152);
        default: high = $urandom_range(10, 20);
      endcase
      run_measurement($urandom_range(0, 5), high);
    end
  endtask

  // Largest register values: longest trigger, full timeout and cap registers
  task automatic test_register_extremes();
    sender_steady = 1'b1;
    configure(8'd255, 16'hFFFF, 16'hFFFF, UNIT_MM);
    run_measurement(3, 20);
    sender_steady = 1'b0;
  endtask

  // Random settings; mostly well-formed measurements, some noise and pauses
  task automatic test_random_traffic();
    int stop_at;
    int phase_end;
    int n;
    logic [15:0] cap;
    logic [15:0] timeout;
    stop_at = active_items + RANDOM_ITEMS;
    while (active_items < stop_at) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      timeout = 16'($urandom_range(0, 40));
      cap = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(60, 100))
                                        : 16'($urandom_range(0, 40));
      configure(8'($urandom_range(0, 12)), timeout, cap, 2'($urandom_range(0, 3)));
      phase_end = active_items + $urandom_range(30, 60);
      while (active_items < phase_end) begin
        case ($urandom_range(0, 9))
          0: begin
            n = $urandom_range(1, 12);
            repeat (n) send_tick(coin(), coin());
            finish_measurement();
          end
          1: begin
            n = $urandom_range(1, 5);
            repeat (n) send_tick(1'b0, coin());
          end
          2: quiesce();
          default: run_measurement($urandom_range(0, count_limit(timeout) + 2),
                                   $urandom_range(0, count_limit(cap) + 2));
        endcase
      end
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_start_req  = 1'b0;
    in_echo_level = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_corners();
    test_unit_modes();
    test_register_extremes();
    test_random_traffic();

    // Drain the pipeline and let any stray item show up
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && tick_result_q.size() == 0) begin
      $display("ultrasonic_echo_ranger: match");
    end else begin
      $display("ultrasonic_echo_ranger: mismatch");
    end
    $finish;
  end

endmodule
